[rtl/core/psq_pkg.sv]
// Package for the polyline stroke quad block.
// Holds default sizes, the multiplier width and the sequencer state type.
// No dependencies.
package psq_pkg;

    localparam int COORD_BITS_DEF    = 20;
    localparam int DIR_FRAC_BITS_DEF = 14;
    localparam int WIDTH_BITS        = 12;
    localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_RST = 12'd16;
    localparam int MUL_W             = 33;
    localparam int PROD_W            = 64;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_NORM  = 8'b0000_0010,
        S_SQ    = 8'b0000_0100,
        S_SQRT  = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_SCALE = 8'b0010_0000,
        S_DOT   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

endpackage

[rtl/core/psq_ifs.sv]
// Handshake channels of the polyline stroke quad block: points in, vertices out.
// Depends on psq_pkg for the default coordinate width.
interface psq_pt_if #(parameter int COORD_BITS = psq_pkg::COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         path_start;
    modport source (output valid, point_x, point_y, path_start, input ready);
    modport sink   (input valid, point_x, point_y, path_start, output ready);
endinterface

interface psq_vtx_if #(parameter int COORD_BITS = psq_pkg::COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         run_last;
    modport source (output valid, vertex_x, vertex_y, run_last, input ready);
    modport sink   (input valid, vertex_x, vertex_y, run_last, output ready);
endinterface

[rtl/core/psq_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on psq_pkg for operand and product widths.
module psq_mul (
    input  logic                                 i_clk,
    input  logic signed [psq_pkg::MUL_W-1:0]     i_a,
    input  logic signed [psq_pkg::MUL_W-1:0]     i_b,
    output logic signed [psq_pkg::PROD_W-1:0]    o_prod
);
    logic signed [2*psq_pkg::MUL_W-1:0] full;
    logic signed [psq_pkg::PROD_W-1:0]  r_prod;

    assign full   = i_a * i_b;
    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= full[psq_pkg::PROD_W-1:0];
    end
endmodule

[rtl/core/polyline_stroke_quads.sv]
// Polyline stroke quad generator, top level.
// Depends on psq_pkg, psq_pt_if, psq_vtx_if and psq_mul.
//
// One point is taken at a time; the block is busy until the last vertex of that
// point has gone into the output register. A start point only becomes the new
// anchor. A later point goes through normalising shifts (one bit a cycle), the
// squares, a square root (one result bit a cycle), two restoring divides (a
// load, then one quotient bit a cycle), width scaling, turn tests and 4 or 8
// vertices, the vertex step waiting on any output stall; a zero-length segment
// goes from the shifts straight to width scaling. All products go through one
// shared multiplier.
module polyline_stroke_quads #(
    parameter int COORD_BITS    = psq_pkg::COORD_BITS_DEF,
    parameter int DIR_FRAC_BITS = psq_pkg::DIR_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [psq_pkg::WIDTH_BITS-1:0]  i_cfg_wdata,
    psq_pt_if.sink                          i_pt,
    psq_vtx_if.source                       o_vtx
);
    localparam int CW  = COORD_BITS;
    localparam int F   = DIR_FRAC_BITS;
    localparam int MW  = psq_pkg::MUL_W;
    localparam int DW  = F + 2;
    localparam int UPW = 14;
    localparam int NW  = 32 + F;
    localparam int SW  = CW + UPW;
    localparam logic signed [SW-1:0] VMAX = SW'((64'(1) << (CW - 1)) - 64'(1));
    localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

    psq_pkg::t_state r_state;
    logic [5:0]  r_k;
    logic        r_have_point, r_have_dir, r_which, r_dot_ok, r_left, r_fill;
    logic [psq_pkg::WIDTH_BITS-1:0] r_width;
    logic signed [CW-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [DW-1:0] r_pdx, r_pdy, r_dx, r_dy;
    logic signed [UPW-1:0] r_upx, r_upy, r_pux, r_puy;
    logic        r_sx, r_sy;
    logic [MW-1:0] r_mx, r_my;
    logic [63:0] r_acc, r_v, r_r;
    logic [31:0] r_len, r_rem;
    logic [F:0]  r_nlo, r_q;
    logic        r_ov, r_olast;
    logic signed [CW-1:0] r_ox, r_oy;

    logic signed [psq_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [psq_pkg::PROD_W-1:0] prod;

    psq_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_prod(prod));

    function automatic logic signed [UPW-1:0] f_rnd(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [63:0] r;
        mag = p[63] ? 64'(-p) : 64'(p);
        r   = (mag + (64'(1) << F)) >> (F + 1);
        return p[63] ? -$signed(UPW'(r)) : $signed(UPW'(r));
    endfunction

    function automatic logic signed [CW-1:0] f_sat(input logic signed [CW-1:0] b,
                                                    input logic signed [UPW-1:0] o);
        logic signed [SW-1:0] s;
        s = SW'(b) + SW'(o);
        if (s > VMAX) begin
            s = VMAX;
        end else if (s < VMIN) begin
            s = VMIN;
        end
        return s[CW-1:0];
    endfunction

    logic signed [CW:0] in_dx, in_dy;
    logic [CW:0]  in_mx, in_my;
    logic [MW-1:0] m_max;
    logic [63:0]  sq_bit, sq_trial;
    logic [NW-1:0] num;
    logic [32:0]  div_t;
    logic         div_ge;
    logic [F:0]   q_fin;
    logic signed [DW-1:0] dir_fin;
    logic signed [63:0] dot_sum;
    logic signed [CW-1:0] vb_x, vb_y;
    logic signed [UPW-1:0] vo_x, vo_y;
    logic         out_load;

    assign in_dx  = (CW+1)'(i_pt.point_x) - (CW+1)'(r_ax);
    assign in_dy  = (CW+1)'(i_pt.point_y) - (CW+1)'(r_ay);
    assign in_mx  = in_dx[CW] ? (CW+1)'(-in_dx) : (CW+1)'(in_dx);
    assign in_my  = in_dy[CW] ? (CW+1)'(-in_dy) : (CW+1)'(in_dy);
    assign m_max  = (r_mx > r_my) ? r_mx : r_my;
    assign sq_bit = 64'(1) << (6'd62 - {r_k[4:0], 1'b0});
    assign sq_trial = r_r + sq_bit;
    assign num    = (NW'(r_which ? r_my[30:0] : r_mx[30:0]) << F) + NW'(r_len[31:1]);
    assign div_t  = {r_rem, r_nlo[F]};
    assign div_ge = div_t >= {1'b0, r_len};
    assign q_fin  = {r_q[F-1:0], div_ge};
    assign dir_fin = (r_which ? r_sy : r_sx) ? -$signed(DW'(q_fin)) : $signed(DW'(q_fin));
    assign dot_sum = $signed(r_acc) + prod;
    assign out_load = (r_state == psq_pkg::S_EMIT) && (!r_ov || o_vtx.ready);

    assign i_pt.ready     = (r_state == psq_pkg::S_IDLE);
    assign o_vtx.valid    = r_ov;
    assign o_vtx.vertex_x = r_ox;
    assign o_vtx.vertex_y = r_oy;
    assign o_vtx.run_last = r_olast;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            psq_pkg::S_SQ: begin
                mul_a = (r_k == 6'd0) ? $signed(r_mx) : $signed(r_my);
                mul_b = mul_a;
            end
            psq_pkg::S_SCALE: begin
                mul_b = $signed(MW'({1'b0, r_width}));
                case (r_k[1:0])
                    2'd0:    mul_a = MW'(r_dy);
                    2'd1:    mul_a = MW'(r_dx);
                    2'd2:    mul_a = MW'(r_pdy);
                    default: mul_a = MW'(r_pdx);
                endcase
            end
            psq_pkg::S_DOT: begin
                case (r_k[1:0])
                    2'd0:    begin mul_a = MW'(r_pdx); mul_b = MW'(r_dx); end
                    2'd1:    begin mul_a = MW'(r_pdy); mul_b = MW'(r_dy); end
                    2'd2:    begin mul_a = MW'(r_pux); mul_b = MW'(r_dx); end
                    default: begin mul_a = MW'(r_puy); mul_b = MW'(r_dy); end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        vb_x = r_ax;
        vb_y = r_ay;
        vo_x = '0;
        vo_y = '0;
        case (r_k[2:0])
            3'd2: begin
                vo_x = r_left ? -r_upx : r_pux;
                vo_y = r_left ? -r_upy : r_puy;
            end
            3'd3: begin
                vo_x = r_left ? -r_pux : r_upx;
                vo_y = r_left ? -r_puy : r_upy;
            end
            3'd4: begin
                vo_x = r_upx;
                vo_y = r_upy;
            end
            3'd5: begin
                vb_x = r_bx; vb_y = r_by;
                vo_x = r_upx; vo_y = r_upy;
            end
            3'd6: begin
                vb_x = r_bx; vb_y = r_by;
                vo_x = -r_upx; vo_y = -r_upy;
            end
            3'd7: begin
                vo_x = -r_upx;
                vo_y = -r_upy;
            end
            default: begin
                vo_x = '0;
                vo_y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= psq_pkg::S_IDLE;
            r_k          <= '0;
            r_have_point <= 1'b0;
            r_have_dir   <= 1'b0;
            r_width      <= psq_pkg::LINE_WIDTH_RST;
            r_ax         <= '0;
            r_ay         <= '0;
            r_pdx        <= '0;
            r_pdy        <= '0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
            if (out_load) begin
                r_ov    <= 1'b1;
                r_ox    <= f_sat(vb_x, vo_x);
                r_oy    <= f_sat(vb_y, vo_y);
                r_olast <= (r_k[2:0] == 3'd7);
            end else if (o_vtx.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                psq_pkg::S_IDLE: begin
                    if (i_pt.valid) begin
                        if (i_pt.path_start || !r_have_point) begin
                            r_ax         <= i_pt.point_x;
                            r_ay         <= i_pt.point_y;
                            r_have_point <= 1'b1;
                            r_have_dir   <= 1'b0;
                        end else begin
                            r_bx    <= i_pt.point_x;
                            r_by    <= i_pt.point_y;
                            r_sx    <= in_dx[CW];
                            r_sy    <= in_dy[CW];
                            r_mx    <= MW'(in_mx);
                            r_my    <= MW'(in_my);
                            r_state <= psq_pkg::S_NORM;
                        end
                    end
                end
                psq_pkg::S_NORM: begin
                    r_k <= '0;
                    if (m_max == '0) begin
                        r_dx    <= '0;
                        r_dy    <= '0;
                        r_state <= psq_pkg::S_SCALE;
                    end else if (m_max[MW-1:31] != '0) begin
                        r_mx <= r_mx >> 1;
                        r_my <= r_my >> 1;
                    end else if (!m_max[30]) begin
                        r_mx <= r_mx << 1;
                        r_my <= r_my << 1;
                    end else begin
                        r_state <= psq_pkg::S_SQ;
                    end
                end
                psq_pkg::S_SQ: begin
                    r_k <= r_k + 6'd1;
                    if (r_k == 6'd1) begin
                        r_acc <= 64'(prod);
                    end else if (r_k == 6'd2) begin
                        r_v     <= r_acc + 64'(prod);
                        r_r     <= '0;
                        r_k     <= '0;
                        r_state <= psq_pkg::S_SQRT;
                    end
                end
                psq_pkg::S_SQRT: begin
                    if (r_v >= sq_trial) begin
                        r_v <= r_v - sq_trial;
                        r_r <= (r_r >> 1) + sq_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_k <= r_k + 6'd1;
                    if (r_k == 6'd31) begin
                        r_k     <= 6'd63;
                        r_which <= 1'b0;
                        r_len   <= (r_v >= sq_trial) ? 32'((r_r >> 1) + sq_bit)
                                                     : 32'(r_r >> 1);
                        r_state <= psq_pkg::S_DIV;
                    end
                end
                psq_pkg::S_DIV: begin
                    if (r_k == 6'd63) begin
                        r_rem <= 32'(num[NW-1:F+1]);
                        r_nlo <= num[F:0];
                        r_q   <= '0;
                        r_k   <= '0;
                    end else begin
                        r_nlo <= r_nlo << 1;
                        r_q   <= q_fin;
                        if (div_ge) begin
                            r_rem <= 32'(div_t - {1'b0, r_len});
                        end else begin
                            r_rem <= div_t[31:0];
                        end
                        r_k <= r_k + 6'd1;
                        if (r_k == 6'(F)) begin
                            if (r_which) begin
                                r_dy    <= dir_fin;
                                r_k     <= '0;
                                r_state <= psq_pkg::S_SCALE;
                            end else begin
                                r_dx    <= dir_fin;
                                r_which <= 1'b1;
                                r_k     <= 6'd63;
                            end
                        end
                    end
                end
                psq_pkg::S_SCALE: begin
                    r_k <= r_k + 6'd1;
                    case (r_k[2:0])
                        3'd1: r_upx <= f_rnd(prod);
                        3'd2: r_upy <= -f_rnd(prod);
                        3'd3: r_pux <= f_rnd(prod);
                        3'd4: begin
                            r_puy   <= -f_rnd(prod);
                            r_k     <= '0;
                            r_state <= psq_pkg::S_DOT;
                        end
                        default: r_k <= r_k + 6'd1;
                    endcase
                end
                psq_pkg::S_DOT: begin
                    r_k <= r_k + 6'd1;
                    case (r_k[2:0])
                        3'd1: r_acc <= 64'(prod);
                        3'd2: r_dot_ok <= !dot_sum[63];
                        3'd3: r_acc <= 64'(prod);
                        3'd4: begin
                            r_fill  <= r_have_dir && r_dot_ok && (dot_sum != '0);
                            r_left  <= !dot_sum[63];
                            r_k     <= (r_have_dir && r_dot_ok && (dot_sum != '0))
                                       ? 6'd0 : 6'd4;
                            r_state <= psq_pkg::S_EMIT;
                        end
                        default: r_k <= r_k + 6'd1;
                    endcase
                end
                psq_pkg::S_EMIT: begin
                    if (out_load) begin
                        r_k <= r_k + 6'd1;
                        if (r_k[2:0] == 3'd7) begin
                            r_ax       <= r_bx;
                            r_ay       <= r_by;
                            r_pdx      <= r_dx;
                            r_pdy      <= r_dy;
                            r_have_dir <= 1'b1;
                            r_state    <= psq_pkg::S_IDLE;
                        end
                    end
                end
                default: r_state <= psq_pkg::S_IDLE;
            endcase
        end
    end

endmodule

[test/tb.sv]
// Self-checking testbench for polyline_stroke_quads: points in, quad vertices out.
// Depends on psq_pkg, psq_pt_if, psq_vtx_if and the block itself.
module tb;

    localparam int CB = psq_pkg::COORD_BITS_DEF;
    localparam int DF = psq_pkg::DIR_FRAC_BITS_DEF;
    localparam int WB = psq_pkg::WIDTH_BITS;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam longint CMAXV = (64'sd1 <<< (CB - 1)) - 1;
    localparam longint CMINV = -(64'sd1 <<< (CB - 1));

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 last;
    } t_vertex;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [WB-1:0] i_cfg_wdata = '0;

    psq_pt_if  #(.COORD_BITS(CB)) pt ();
    psq_vtx_if #(.COORD_BITS(CB)) vtx ();

    polyline_stroke_quads #(.COORD_BITS(CB), .DIR_FRAC_BITS(DF)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_pt(pt), .o_vtx(vtx)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [WB-1:0] width_now = psq_pkg::LINE_WIDTH_RST;
    longint last_x, last_y, last_dx, last_dy;
    bit has_pt, has_dir;
    t_vertex expected_vertices[$];

    int errors = 0;
    int points_sent = 0;
    int vertices_seen = 0;
    int idle_cycles = 0;
    int rx_wait = 0;
    bit hold_off = 1'b0;
    bit done_flag = 1'b0;

    function automatic longint iroot(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic unit_dir(input longint dx, input longint dy,
                            output longint ox, output longint oy);
        longint unsigned mx, my, m, len, qx, qy;
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        m = mx > my ? mx : my;
        if (m == 0) begin
            ox = 0;
            oy = 0;
            return;
        end
        while (m >= (64'd1 << 31)) begin
            mx >>= 1; my >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 30)) begin
            mx <<= 1; my <<= 1; m <<= 1;
        end
        len = iroot(mx * mx + my * my);
        qx = ((mx << DF) + len / 2) / len;
        qy = ((my << DF) + len / 2) / len;
        ox = dx < 0 ? -longint'(qx) : longint'(qx);
        oy = dy < 0 ? -longint'(qy) : longint'(qy);
    endtask

    function automatic longint half_width(longint d);
        longint p, r;
        longint unsigned mag;
        p = d * longint'(width_now);
        mag = p < 0 ? -p : p;
        r = longint'((mag + (64'd1 << DF)) >> (DF + 1));
        return p < 0 ? -r : r;
    endfunction

    function automatic logic signed [CB-1:0] clamp(longint v);
        if (v > CMAXV) return CMAXV[CB-1:0];
        if (v < CMINV) return CMINV[CB-1:0];
        return v[CB-1:0];
    endfunction

    task automatic push_vertex(input longint x, input longint y);
        t_vertex v;
        v.x = clamp(x);
        v.y = clamp(y);
        v.last = 1'b0;
        expected_vertices = {expected_vertices, v};
    endtask

    task automatic predict_point(input logic signed [CB-1:0] px,
                                 input logic signed [CB-1:0] py, input bit start);
        longint bx, by, ax, ay, dx, dy, ux, uy, pux, puy, t;
        bx = longint'(px);
        by = longint'(py);
        if (start || !has_pt) begin
            last_x = bx; last_y = by;
            has_pt = 1; has_dir = 0;
            return;
        end
        ax = last_x; ay = last_y;
        unit_dir(bx - ax, by - ay, dx, dy);
        ux = half_width(dy);
        uy = -half_width(dx);
        if (has_dir && last_dx * dx + last_dy * dy >= 0) begin
            pux = half_width(last_dy);
            puy = -half_width(last_dx);
            t = pux * dx + puy * dy;
            if (t > 0) begin
                push_vertex(ax, ay); push_vertex(ax, ay);
                push_vertex(ax - ux, ay - uy); push_vertex(ax - pux, ay - puy);
            end else if (t < 0) begin
                push_vertex(ax, ay); push_vertex(ax, ay);
                push_vertex(ax + pux, ay + puy); push_vertex(ax + ux, ay + uy);
            end
        end
        push_vertex(ax + ux, ay + uy);
        push_vertex(bx + ux, by + uy);
        push_vertex(bx - ux, by - uy);
        push_vertex(ax - ux, ay - uy);
        expected_vertices[expected_vertices.size() - 1].last = 1'b1;
        last_x = bx; last_y = by;
        last_dx = dx; last_dy = dy;
        has_dir = 1;
    endtask

    task automatic report(input string msg);
        errors++;
        $display("vertex %0d: %s", vertices_seen, msg);
    endtask

    task automatic send_point(input int px, input int py, input bit start,
                              input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : int'($urandom_range(0, 4));
        if (gap > 0) begin
            pt.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt.valid <= 1'b1;
        pt.point_x <= CB'(px);
        pt.point_y <= CB'(py);
        pt.path_start <= start;
        @(posedge i_clk);
        while (!pt.ready) @(posedge i_clk);
        predict_point(CB'(px), CB'(py), start);
        points_sent++;
    endtask

    task automatic drain();
        pt.valid <= 1'b0;
        while (expected_vertices.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [WB-1:0] w);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        width_now = w;
    endtask

    function automatic int rand_coord(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // vertex receiver
    always @(posedge i_clk) begin
        t_vertex w;
        if (!i_rst_n) begin
            vtx.ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (vtx.valid && vtx.ready) begin
                if (expected_vertices.size() == 0) begin
                    report($sformatf("unexpected vertex %0d,%0d",
                                     vtx.vertex_x, vtx.vertex_y));
                end else begin
                    w = expected_vertices.pop_front();
                    if (vtx.vertex_x !== w.x)
                        report($sformatf("x got %0d want %0d", vtx.vertex_x, w.x));
                    if (vtx.vertex_y !== w.y)
                        report($sformatf("y got %0d want %0d", vtx.vertex_y, w.y));
                    if (vtx.run_last !== w.last)
                        report($sformatf("last got %0d want %0d", vtx.run_last, w.last));
                end
                vertices_seen++;
                rx_wait = int'($urandom_range(0, 4));
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            vtx.ready <= !hold_off && (rx_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !done_flag) begin
            if ((pt.valid && pt.ready) || (vtx.valid && vtx.ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_point(0, 0, 1'b0);
        send_point(160, 0, 1'b0);
        send_point(160, 160, 1'b0);
        send_point(320, 320, 1'b0);
        send_point(320, 0, 1'b0);
        send_point(320, 0, 1'b0);
        send_point(0, 0, 1'b0);
        send_point(524287, 524287, 1'b1);
        send_point(-524288, -524288, 1'b0);
        send_point(-524288, 524287, 1'b0);
        send_point(524287, -524288, 1'b0);
        send_point(100, 100, 1'b1);
        send_point(101, 99, 1'b0);
        send_point(103, 102, 1'b0);
    endtask

    task automatic test_widths();
        logic [WB-1:0] ws[4] = '{12'd0, 12'd4095, 12'd1, 12'd37};
        foreach (ws[k]) begin
            write_width(ws[k]);
            send_point(0, 0, 1'b1);
            send_point(200, 50, 1'b0);
            send_point(250, 300, 1'b0);
            send_point(-100, 250, 1'b0);
            send_point(524287, 0, 1'b0);
        end
    endtask

    task automatic test_random(input int count);
        int span;
        for (int k = 0; k < count; k++) begin
            if (k % 60 == 59) write_width(WB'($urandom_range(0, 4095)));
            span = ($urandom_range(0, 7) == 0) ? 524287 : int'($urandom_range(1, 3000));
            send_point(rand_coord(span), rand_coord(span), $urandom_range(0, 11) == 0);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 6; k++)
                send_point(rand_coord(2000), rand_coord(2000), 1'b0, 1'b1);
        join
        drain();
        send_point(rand_coord(2000), rand_coord(2000), 1'b0);
    endtask

    initial begin
        pt.valid = 1'b0;
        pt.point_x = '0;
        pt.point_y = '0;
        pt.path_start = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_widths();
        test_backpressure();
        test_random(280);
        drain();
        done_flag = 1'b1;
        $display("Sent %0d points, checked %0d vertices across several line widths.",
                 points_sent, vertices_seen);
        if (errors == 0 && expected_vertices.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/core/psq_pkg.sv
rtl/core/psq_ifs.sv
rtl/core/psq_mul.sv
rtl/core/polyline_stroke_quads.sv
test/tb.sv
